// ----- sv/matb_pkg.sv -----
package matb_pkg;

  localparam int unsigned ChunkBits  = 4;
  localparam int unsigned NumChunks  = 8;
  localparam int unsigned WordBits   = ChunkBits * NumChunks;
  localparam int unsigned DataBits   = 32;
  localparam int unsigned RandBits   = 4;
  localparam int unsigned TabIdxBits = ChunkBits + 1;
  localparam int unsigned TabDepth   = 2 ** TabIdxBits;
  localparam int unsigned WalkBits   = (NumChunks > 1) ? $clog2(NumChunks) : 1;
  localparam int unsigned CntBits    = (ChunkBits > WalkBits) ? ChunkBits : WalkBits;
  localparam int unsigned CinBits    = 2;
  localparam int unsigned InBits     = 2 * DataBits + 1 + RandBits;
  localparam int unsigned InTdataBits = ((InBits + 7) / 8) * 8;

  typedef logic [ChunkBits-1:0] chunk_t;
  typedef logic [ChunkBits:0]   entry_t;

  typedef struct packed {
    chunk_t val;
    chunk_t msk;
    chunk_t res;
  } slice_t;

  typedef struct packed {
    logic   en;
    chunk_t a;
    logic   rho;
    chunk_t r;
  } tab_wr_t;

  // randomized carry table entry: (a + r + carry) ^ {rho, r}, carry = row ^ rho
  function automatic entry_t build_entry(logic row, chunk_t a, logic rho, chunk_t r);
    entry_t sum;
    entry_t key;
    sum = {1'b0, a} + {1'b0, r} + {{ChunkBits{1'b0}}, row ^ rho};
    key = {rho, r};
    return sum ^ key;
  endfunction

  function automatic chunk_t rand_to_chunk(logic [RandBits-1:0] x);
    chunk_t c;
    c = '0;
    for (int unsigned b = 0; b < ChunkBits; b++) begin
      if (b < RandBits) begin
        c[b] = x[b % RandBits];
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/matb_cell.sv -----
module matb_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            shift_i,
  input  matb_pkg::slice_t par_i,
  input  matb_pkg::slice_t nbr_i,
  output matb_pkg::slice_t slice_o
);

  matb_pkg::slice_t slice_q;
  matb_pkg::slice_t slice_d;

  always_comb begin
    slice_d = slice_q;
    if (load_i) begin
      slice_d = par_i;
    end else if (shift_i) begin
      slice_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slice_q <= slice_d;
  end

  assign slice_o = slice_q;

endmodule

// ----- sv/matb_table.sv -----
module matb_table (
  input  logic                              clk_i,
  input  matb_pkg::tab_wr_t                 wr_i,
  input  logic [matb_pkg::TabIdxBits-1:0]   rd_idx_i,
  output matb_pkg::entry_t                  rd_data_o
);

  matb_pkg::entry_t mem_q [matb_pkg::TabDepth];

  // one build step fills the entry for carry-masked row and its complement row
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[{wr_i.rho, wr_i.a}]  <= matb_pkg::build_entry(wr_i.rho, wr_i.a, wr_i.rho, wr_i.r);
      mem_q[{~wr_i.rho, wr_i.a}] <= matb_pkg::build_entry(~wr_i.rho, wr_i.a, wr_i.rho,
                                                          wr_i.r);
    end
  end

  assign rd_data_o = mem_q[rd_idx_i];

endmodule

// ----- sv/masked_arith_to_bool_table_core.sv -----
// Channel   Dir  tdata fields (low bit up)
// s_axis    in   masked_value[31:0], arith_mask[63:32], carry_mask_bit[64],
//                chunk_mask[68:65], zero[71:69]
// m_axis    out  bool_share[31:0]
//
// Steps per transaction, one transaction at a time: accept, table build two
// entries a cycle, one chunk lookup a cycle through the cell chain, hand-off to
// the output register once it is free.
// The output register lets a new transaction start while the result waits.
// rst_ni clears control only; the table needs no clearing, each item rebuilds it.
module masked_arith_to_bool_table_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // masked_value, arith_mask, carry_mask_bit, chunk_mask, zero pad
  input  logic [matb_pkg::InTdataBits-1:0]   s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // bool_share
  output logic [matb_pkg::DataBits-1:0]      m_axis_tdata_o
);

  localparam int unsigned K = matb_pkg::ChunkBits;
  localparam int unsigned N = matb_pkg::NumChunks;
  localparam int unsigned W = matb_pkg::WordBits;
  localparam int unsigned D = matb_pkg::DataBits;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StBuild = 2'd1;
  localparam logic [1:0] StWalk  = 2'd2;
  localparam logic [1:0] StHold  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [matb_pkg::CntBits-1:0] cnt_q, cnt_d;
  logic rho_q, rho_d;
  logic beta_q, beta_d;
  logic [matb_pkg::CinBits-1:0] cin_q, cin_d;
  matb_pkg::chunk_t r_q, r_d;
  logic out_valid_q, out_valid_d;
  logic [D-1:0] out_q, out_d;

  logic [D-1:0] mv_in, am_in;
  logic cmb_in;
  logic [matb_pkg::RandBits-1:0] cm_in;
  logic [W-1:0] mv_w, am_w, res_w;
  logic [D-1:0] res_d;

  logic accept, load, shift, out_free, build_last, walk_last;
  matb_pkg::slice_t slices [N];
  matb_pkg::slice_t tail;
  matb_pkg::slice_t head;
  logic [K+1:0] sum;
  matb_pkg::chunk_t al, bi;
  matb_pkg::entry_t rd_data;
  matb_pkg::tab_wr_t tab_wr;

  assign mv_in  = s_axis_tdata_i[D-1:0];
  assign am_in  = s_axis_tdata_i[2*D-1:D];
  assign cmb_in = s_axis_tdata_i[2*D];
  assign cm_in  = s_axis_tdata_i[2*D+matb_pkg::RandBits:2*D+1];

  for (genvar b = 0; b < W; b++) begin : g_win
    if (b < D) begin : g_in
      assign mv_w[b] = mv_in[b];
      assign am_w[b] = am_in[b];
    end else begin : g_zero
      assign mv_w[b] = 1'b0;
      assign am_w[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < D; b++) begin : g_wout
    if (b < W) begin : g_res
      assign res_d[b] = res_w[b];
    end else begin : g_zero
      assign res_d[b] = 1'b0;
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign load     = accept;
  assign shift    = (state_q == StWalk);
  assign build_last = (cnt_q[K-1:0] == {K{1'b1}});
  assign walk_last  = (cnt_q == matb_pkg::CntBits'(N - 1));

  assign head = slices[0];
  assign sum  = {2'b00, head.val} + {2'b00, head.msk} + {2'b00, ~r_q}
              + {{K{1'b0}}, cin_q};
  assign al   = sum[K-1:0];
  assign bi   = rd_data[K-1:0] ^ head.msk ^ r_q;

  always_comb begin
    tail     = '0;
    tail.res = bi;
  end

  for (genvar i = 0; i < N; i++) begin : g_chain
    matb_pkg::slice_t par;
    matb_pkg::slice_t nbr;
    assign par.val = mv_w[i*K +: K];
    assign par.msk = am_w[i*K +: K];
    assign par.res = '0;
    if (i == N - 1) begin : g_last
      assign nbr = tail;
    end else begin : g_mid
      assign nbr = slices[i+1];
    end
    assign res_w[i*K +: K] = slices[i].res;

    matb_cell u_cell (
      .clk_i   (clk_i),
      .load_i  (load),
      .shift_i (shift),
      .par_i   (par),
      .nbr_i   (nbr),
      .slice_o (slices[i])
    );
  end

  assign tab_wr.en  = (state_q == StBuild);
  assign tab_wr.a   = cnt_q[K-1:0];
  assign tab_wr.rho = rho_q;
  assign tab_wr.r   = r_q;

  matb_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tab_wr),
    .rd_idx_i  ({beta_q, al}),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rho_d       = rho_q;
    beta_d      = beta_q;
    cin_d       = cin_q;
    r_d         = r_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept) begin
          rho_d   = cmb_in;
          beta_d  = cmb_in;
          r_d     = matb_pkg::rand_to_chunk(cm_in);
          cin_d   = matb_pkg::CinBits'(1);
          cnt_d   = '0;
          state_d = StBuild;
        end
      end
      StBuild: begin
        cnt_d = cnt_q + 1'b1;
        if (build_last) begin
          cnt_d   = '0;
          state_d = StWalk;
        end
      end
      StWalk: begin
        beta_d = rd_data[K];
        cin_d  = sum[K+1:K];
        cnt_d  = cnt_q + 1'b1;
        if (walk_last) begin
          state_d = StHold;
        end
      end
      StHold: begin
        if (out_free) begin
          out_d       = res_d;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rho_q  <= rho_d;
    beta_q <= beta_d;
    cin_q  <= cin_d;
    r_q    <= r_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// ----- tb/sv/masked_arith_to_bool_table_core_chk.sv -----
module masked_arith_to_bool_table_core_chk (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  // masked_value, arith_mask, carry_mask_bit, chunk_mask, zero pad
  input  logic [matb_pkg::InTdataBits-1:0] s_axis_tdata_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  // bool_share
  input  logic [matb_pkg::DataBits-1:0]    m_axis_tdata_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o,
  output int unsigned                      results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import matb_pkg::*;

  logic [DataBits-1:0] expected_shares [$];

  function automatic logic [DataBits-1:0] predict_bool_share(
    input logic [DataBits-1:0] share,
    input logic [DataBits-1:0] mask,
    input logic                rho,
    input logic [RandBits-1:0] rnd
  );
    logic [TabIdxBits-1:0] carry_tab [TabDepth];
    logic [TabIdxBits-1:0] key;
    logic [TabIdxBits-1:0] ent;
    chunk_t                r;
    chunk_t                rl;
    chunk_t                al;
    chunk_t                bi;
    logic                  beta;
    logic [63:0]           full;
    logic [63:0]           rep;
    logic [63:0]           acc;
    logic [63:0]           rm;
    logic [63:0]           live;
    logic [63:0]           outw;
    int                    sh;
    r    = rnd;
    full = (WordBits >= 64) ? '1 : ((64'd1 << WordBits) - 64'd1);
    rep  = '0;
    for (int i = 0; i < NumChunks; i++) begin
      sh = i * ChunkBits;
      if (sh < 64) begin
        rep |= 64'(r) << sh;
      end
    end
    rep &= full;
    // randomized table: row rho holds carry-free sums, the other row adds one
    key = {rho, r};
    for (int a = 0; a < (1 << ChunkBits); a++) begin
      carry_tab[{rho, chunk_t'(a)}]  = (TabIdxBits'(a) + TabIdxBits'(r)) ^ key;
      carry_tab[{~rho, chunk_t'(a)}] = (TabIdxBits'(a) + TabIdxBits'(r) + 1'b1) ^ key;
    end
    acc  = (64'(share) - rep) & full;
    rm   = 64'(mask) & full;
    live = full;
    beta = rho;
    outw = '0;
    for (int i = 0; i < NumChunks; i++) begin
      sh   = i * ChunkBits;
      rl   = rm[ChunkBits-1:0];
      acc  = (acc + 64'(rl)) & live;
      al   = acc[ChunkBits-1:0];
      ent  = carry_tab[{beta, al}];
      bi   = ent[ChunkBits-1:0] ^ rl;
      beta = ent[ChunkBits];
      if (sh < 64) begin
        outw |= 64'(bi) << sh;
      end
      acc  = acc >> ChunkBits;
      rm   = rm >> ChunkBits;
      live = live >> ChunkBits;
    end
    outw = (outw ^ rep) & full;
    return outw[DataBits-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [DataBits-1:0] exp_share;
    if (!rst_ni) begin
      expected_shares.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        results_o <= results_o + 1;
        if (expected_shares.size() == 0) begin
          $display("%0t: unexpected bool_share %h with no transaction pending",
                   $time, m_axis_tdata_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_share = expected_shares.pop_front();
          if (m_axis_tdata_i !== exp_share) begin
            $display("%0t: bool_share mismatch, expected %h, actual %h",
                     $time, exp_share, m_axis_tdata_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_shares.push_back(predict_bool_share(
          s_axis_tdata_i[DataBits-1:0],
          s_axis_tdata_i[2*DataBits-1:DataBits],
          s_axis_tdata_i[2*DataBits],
          s_axis_tdata_i[2*DataBits+RandBits:2*DataBits+1]));
      end
      pending_o <= expected_shares.size();
    end
  end

endmodule

// ----- tb/sv/masked_arith_to_bool_table_core_tb.sv -----
module masked_arith_to_bool_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import matb_pkg::*;

  localparam int unsigned RandomItems = 1800;
  localparam int unsigned CalmItems   = 200;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned StallLimit  = 2000;

  logic                   clk;
  logic                   rst_n;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [InTdataBits-1:0] s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [DataBits-1:0]    m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  int unsigned sent;
  int unsigned drains;
  int unsigned stall_cycles;
  bit          idle_en;

  masked_arith_to_bool_table_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  masked_arith_to_bool_table_core_chk i_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .results_o       (results)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [InTdataBits-1:0] pack_item(
    input logic [DataBits-1:0] share,
    input logic [DataBits-1:0] mask,
    input logic                carry_bit,
    input logic [RandBits-1:0] cmask
  );
    return InTdataBits'({cmask, carry_bit, mask, share});
  endfunction

  function automatic logic [DataBits-1:0] pick_word();
    logic [DataBits-1:0] w;
    case ($urandom_range(0, 11))
      0: w = '0;
      1: w = '1;
      2: w = {1'b1, {(DataBits-1){1'b0}}};
      3: w = {1'b0, {(DataBits-1){1'b1}}};
      4: w = DataBits'(1);
      5: w = {NumChunks{chunk_t'($urandom_range(0, 15))}};
      default: w = $urandom();
    endcase
    return w;
  endfunction

  task automatic send_item(input logic [InTdataBits-1:0] item);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = item;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = InTdataBits'({$urandom(), $urandom(), $urandom()});
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    drains++;
  endtask

  // sink side backpressure
  initial begin
    int unsigned hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        m_axis_tready = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 7) - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
          $display("masked_arith_to_bool_table_core verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [RandBits-1:0] cm_set [4];
    cm_set = '{4'h0, 4'h1, 4'h8, 4'hF};
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_en       = 1'b1;
    sent          = 0;
    drains        = 0;
    stall_cycles  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: field extremes, carry chains, every carry bit / chunk mask corner
    send_item(pack_item('0, '0, 1'b0, 4'h0));
    send_item(pack_item('1, '1, 1'b1, 4'hF));
    send_item(pack_item('1, '0, 1'b0, 4'h0));
    send_item(pack_item('0, '1, 1'b1, 4'hF));
    send_item(pack_item('1, 32'h0000_0001, 1'b0, 4'h1));
    send_item(pack_item(32'h0000_0001, '1, 1'b1, 4'h8));
    send_item(pack_item(32'h8000_0000, 32'h8000_0000, 1'b0, 4'h7));
    send_item(pack_item(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 4'hA));
    send_item(pack_item(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 4'h5));
    send_item(pack_item(32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1, 4'hF));
    send_item(pack_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 4'hF));
    for (int c = 0; c < 2; c++) begin
      for (int k = 0; k < 4; k++) begin
        send_item(pack_item($urandom(), $urandom(), c[0], cm_set[k]));
      end
    end
    drain_results();

    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) begin
        drain_results();
      end
      if (n == RandomItems - CalmItems) begin
        idle_en = 1'b0;
      end
      send_item(pack_item(pick_word(), pick_word(), 1'($urandom_range(0, 1)),
                          RandBits'($urandom_range(0, 15))));
    end
    s_axis_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Converted %0d shares (%0d results checked), %0d full drains,",
             sent, results, drains);
    $display("random stalls on both channels, then back-to-back traffic.");
    if (fail_count == 0) begin
      $display("masked_arith_to_bool_table_core verification clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("masked_arith_to_bool_table_core verification failed");
    end
    $finish;
  end

endmodule
